>>> rtl/assert_macros.svh
// Assertion helpers shared by the date difference RTL.
// Both macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property check failed");
// Flag a condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/sdd_pkg.sv
`timescale 1ns / 1ps
package sdd_pkg;

    localparam logic [11:0] YEAR_MAX   = 12'd2999;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [4:0]  FEB_LEAP   = 5'd29;

    // floor(x / 100) for x below 4096 as (x * DIV100_MUL) >> DIV100_SH
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam int          PROD_W     = 25;

    localparam int DN_W   = 21;   // day number since 0001-01-01
    localparam int DIFF_W = 22;   // signed day difference

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // One date after checking, ready for the day-number sum.
    typedef struct packed {
        logic [11:0] prev_year;   // year - 1
        logic [4:0]  cent;        // floor((year - 1) / 100)
        logic        late_leap;   // leap year and month past February
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date_info;

    // One classified item, handed from the front to the back.
    typedef struct packed {
        logic       bad;
        logic       end_day;
        t_date_info date_a;
        t_date_info date_b;
    } t_cls;

endpackage

>>> rtl/sdd_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [11:0]  i_year_a,
    input  logic [3:0]   i_month_a,
    input  logic [4:0]   i_day_a,
    input  logic [11:0]  i_year_b,
    input  logic [3:0]   i_month_b,
    input  logic [4:0]   i_day_b,
    input  logic         i_end_day,
    output logic         o_valid,
    input  logic         i_ready,
    output sdd_pkg::t_cls o_cls
);

    logic          r_valid;
    sdd_pkg::t_cls r_cls;
    sdd_pkg::t_cls n_cls;
    logic          w_ok_a;
    logic          w_ok_b;

    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            sdd_pkg::MONTH_FEB: len = leap ? sdd_pkg::FEB_LEAP : 5'd28;
            default:            len = 5'd0;
        endcase
        return len;
    endfunction

    // Leap test without a divider: a year is a century year exactly when
    // floor(y/100) and floor((y-1)/100) differ.
    function automatic sdd_pkg::t_date_info f_info(input logic [11:0] y,
                                                   input logic [3:0] m,
                                                   input logic [4:0] d);
        sdd_pkg::t_date_info info;
        logic [11:0]                 p;
        logic [sdd_pkg::PROD_W-1:0]  prod_y;
        logic [sdd_pkg::PROD_W-1:0]  prod_p;
        logic [5:0]                  qy;
        logic [5:0]                  qp;
        logic                        leap;
        p      = y - 12'd1;
        prod_y = sdd_pkg::PROD_W'(y) * sdd_pkg::PROD_W'(sdd_pkg::DIV100_MUL);
        prod_p = sdd_pkg::PROD_W'(p) * sdd_pkg::PROD_W'(sdd_pkg::DIV100_MUL);
        qy     = prod_y[sdd_pkg::DIV100_SH +: 6];
        qp     = prod_p[sdd_pkg::DIV100_SH +: 6];
        leap   = ((y[1:0] == 2'b00) && (qy == qp)) || ((qy != qp) && (qy[1:0] == 2'b00));
        info.prev_year = p;
        info.cent      = qp[4:0];
        info.late_leap = leap && (m > sdd_pkg::MONTH_FEB);
        info.month     = m;
        info.day       = d;
        return info;
    endfunction

    function automatic logic f_ok(input logic [11:0] y, input logic [3:0] m,
                                  input logic [4:0] d);
        logic [11:0]                p;
        logic [sdd_pkg::PROD_W-1:0] prod_y;
        logic [sdd_pkg::PROD_W-1:0] prod_p;
        logic                       cent_year;
        logic                       leap;
        p         = y - 12'd1;
        prod_y    = sdd_pkg::PROD_W'(y) * sdd_pkg::PROD_W'(sdd_pkg::DIV100_MUL);
        prod_p    = sdd_pkg::PROD_W'(p) * sdd_pkg::PROD_W'(sdd_pkg::DIV100_MUL);
        cent_year = prod_y[sdd_pkg::DIV100_SH +: 6] != prod_p[sdd_pkg::DIV100_SH +: 6];
        leap      = cent_year ? (prod_y[sdd_pkg::DIV100_SH +: 2] == 2'b00)
                              : (y[1:0] == 2'b00);
        return (y != 12'd0) && (y <= sdd_pkg::YEAR_MAX) && (m != 4'd0)
            && (m <= sdd_pkg::MONTH_MAX) && (d != 5'd0) && (d <= f_month_len(m, leap));
    endfunction

    always_comb begin
        w_ok_a         = f_ok(i_year_a, i_month_a, i_day_a);
        w_ok_b         = f_ok(i_year_b, i_month_b, i_day_b);
        n_cls.bad      = !(w_ok_a && w_ok_b);
        n_cls.end_day  = i_end_day;
        n_cls.date_a   = f_info(i_year_a, i_month_a, i_day_a);
        n_cls.date_b   = f_info(i_year_b, i_month_b, i_day_b);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

    `ASSERT_PROP(a_front_hold, i_clk, i_rst_n,
                 (r_valid && !i_ready) |=> (r_valid && $stable(r_cls)))

endmodule

>>> rtl/sdd_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sdd_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output sdd_pkg::t_cls o_cls
);

    sdd_pkg::t_cls             r_mem [sdd_pkg::QDEPTH];
    logic [sdd_pkg::QAW-1:0]   r_wr_ptr;
    logic [sdd_pkg::QAW-1:0]   r_rd_ptr;
    logic [sdd_pkg::QAW:0]     r_count;
    logic                      w_push;
    logic                      w_pop;

    assign o_ready = r_count < (sdd_pkg::QAW+1)'(sdd_pkg::QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cls   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == sdd_pkg::QAW'(sdd_pkg::QDEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == sdd_pkg::QAW'(sdd_pkg::QDEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    `ASSERT_NEVER(a_queue_over, i_clk, i_rst_n,
                  r_count > (sdd_pkg::QAW+1)'(sdd_pkg::QDEPTH))
    `ASSERT_PROP(a_queue_fill, i_clk, i_rst_n,
                 (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

>>> rtl/sdd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  sdd_pkg::t_cls                 i_cls,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sdd_pkg::DIFF_W-1:0]    o_diff,
    output logic                          o_bad
);

    logic                         r_a_valid;
    logic                         r_a_bad;
    logic                         r_a_end;
    logic [sdd_pkg::DN_W-1:0]     r_a_dn1;
    logic [sdd_pkg::DN_W-1:0]     r_a_dn2;
    logic                         r_o_valid;
    logic                         r_o_bad;
    logic [sdd_pkg::DIFF_W-1:0]   r_o_diff;
    logic [sdd_pkg::DIFF_W-1:0]   w_raw;
    logic [sdd_pkg::DIFF_W-1:0]   n_o_diff;
    logic                         w_adv;

    function automatic logic [8:0] f_days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [sdd_pkg::DN_W-1:0] f_day_num(input sdd_pkg::t_date_info di);
        logic [sdd_pkg::DN_W-1:0] n;
        n = sdd_pkg::DN_W'(di.prev_year) * sdd_pkg::DN_W'(365)
          + sdd_pkg::DN_W'(di.prev_year[11:2])
          - sdd_pkg::DN_W'(di.cent)
          + sdd_pkg::DN_W'(di.cent[4:2])
          + sdd_pkg::DN_W'(f_days_before(di.month))
          + sdd_pkg::DN_W'(di.late_leap)
          + sdd_pkg::DN_W'(di.day);
        return n;
    endfunction

    // The whole back pipeline moves together whenever the output slot frees.
    assign w_adv   = !r_o_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_o_valid;
    assign o_diff  = r_o_diff;
    assign o_bad   = r_o_bad;

    always_comb begin
        w_raw = sdd_pkg::DIFF_W'(r_a_dn2) - sdd_pkg::DIFF_W'(r_a_dn1);
        if (r_a_bad) begin
            n_o_diff = '0;
        end else if (!r_a_end) begin
            n_o_diff = w_raw;
        end else if (r_a_dn2 >= r_a_dn1) begin
            n_o_diff = w_raw + 1'b1;
        end else begin
            n_o_diff = w_raw - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_bad  <= i_cls.bad;
            r_a_end  <= i_cls.end_day;
            r_a_dn1  <= f_day_num(i_cls.date_a);
            r_a_dn2  <= f_day_num(i_cls.date_b);
            r_o_bad  <= r_a_bad;
            r_o_diff <= n_o_diff;
        end
    end

    `ASSERT_PROP(a_back_stall, i_clk, i_rst_n,
                 (r_a_valid && !w_adv) |=> (r_a_valid && $stable(r_a_dn1) && $stable(r_a_dn2)))
    `ASSERT_PROP(a_bad_zero, i_clk, i_rst_n,
                 (w_adv && r_a_valid && r_a_bad) |=> (r_o_valid && r_o_bad && (r_o_diff == '0)))

endmodule

>>> rtl/signed_date_difference_days_top.sv
// Signed Gregorian date difference. Throughput one pair of dates per cycle while
// m_axis_tready holds high; an output stall freezes the back pipeline, fills the queue and
// then drops s_axis_tready. Stages: front check, a 2-entry queue, day number, difference.
// Synchronous active-low reset empties the front stage, the queue and the back pipeline.
`timescale 1ns / 1ps
module signed_date_difference_days_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] first_year, [15:12] first_month, [20:16] first_day,
    // [32:21] second_year, [36:33] second_month, [41:37] second_day, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [0] count_end_day
    input  logic        s_axis_tuser,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [21:0] day_difference (two's complement), [23:22] zero
    output logic [23:0] m_axis_tdata,
    // [0] bad_date
    output logic        m_axis_tuser
);

    // Front to queue
    logic          w_f_valid;
    logic          w_f_ready;
    sdd_pkg::t_cls w_f_cls;
    // Queue to back
    logic          w_q_valid;
    logic          w_q_ready;
    sdd_pkg::t_cls w_q_cls;

    logic [sdd_pkg::DIFF_W-1:0] w_diff;

    // Front: check both dates and precompute leap and century terms.
    sdd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_year_a  (s_axis_tdata[11:0]),
        .i_month_a (s_axis_tdata[15:12]),
        .i_day_a   (s_axis_tdata[20:16]),
        .i_year_b  (s_axis_tdata[32:21]),
        .i_month_b (s_axis_tdata[36:33]),
        .i_day_b   (s_axis_tdata[41:37]),
        .i_end_day (s_axis_tuser),
        .o_valid   (w_f_valid),
        .i_ready   (w_f_ready),
        .o_cls     (w_f_cls)
    );

    // Queue: decouple the front from output back-pressure.
    sdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cls   (w_f_cls),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cls   (w_q_cls)
    );

    // Back: form both day numbers, subtract, apply the end-day rule.
    sdd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_cls   (w_q_cls),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_diff  (w_diff),
        .o_bad   (m_axis_tuser)
    );

    // Pad the difference to whole bytes.
    assign m_axis_tdata = {2'b00, w_diff};

endmodule

>>> verif/signed_date_difference_days_top_test.sv
`timescale 1ns / 1ps
module signed_date_difference_days_top_test;

    localparam int RANDOM_PAIRS = 1000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_cal_date;

    typedef struct packed {
        logic signed [sdd_pkg::DIFF_W-1:0] days;
        logic                              bad;
    } t_day_diff;

    // Expected day differences in transfer order, with the calendar arithmetic that
    // produces them.
    class date_diff_board;
        t_day_diff expected_diffs[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(int unsigned y, int unsigned m);
            case (m)
                4, 6, 9, 11:        return 30;
                sdd_pkg::MONTH_FEB: return is_leap_year(y) ? int'(sdd_pkg::FEB_LEAP) : 28;
                default:            return 31;
            endcase
        endfunction

        function bit date_in_range(t_cal_date dt);
            return dt.year >= 1 && dt.year <= sdd_pkg::YEAR_MAX && dt.month >= 1
                && dt.month <= sdd_pkg::MONTH_MAX && dt.day >= 1
                && dt.day <= days_in_month(dt.year, dt.month);
        endfunction

        // Days from 0001-01-01 to the first of the month plus the day of the month.
        function int day_ordinal(t_cal_date dt);
            int p;
            int n;
            p = int'(dt.year) - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400 + int'(dt.day);
            for (int k = 1; k < dt.month; k++)
                n += days_in_month(dt.year, k);
            return n;
        endfunction

        function void note_dates(t_cal_date a, t_cal_date b, logic end_day);
            t_day_diff res;
            int        span;
            res.bad  = 1'b0;
            res.days = '0;
            if (!date_in_range(a) || !date_in_range(b)) begin
                res.bad = 1'b1;
            end else begin
                span = day_ordinal(b) - day_ordinal(a);
                // count the end day away from zero, equal dates give +1
                if (end_day)
                    span += (span >= 0) ? 1 : -1;
                res.days = span[sdd_pkg::DIFF_W-1:0];
            end
            expected_diffs.push_back(res);
        endfunction

        function void check_difference(logic signed [sdd_pkg::DIFF_W-1:0] days, logic bad);
            t_day_diff want;
            if (expected_diffs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: days %0d bad %0b", days, bad);
                return;
            end
            want = expected_diffs.pop_front();
            if (days !== want.days || bad !== want.bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected days %0d bad %0b, got days %0d bad %0b",
                             want.days, want.bad, days, bad);
            end
        endfunction

        function int pending();
            return expected_diffs.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [11:0] first_year, [15:12] first_month, [20:16] first_day,
    // [32:21] second_year, [36:33] second_month, [41:37] second_day, [47:42] zero
    logic [47:0] s_axis_tdata  = '0;
    // [0] count_end_day
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [21:0] day_difference (two's complement), [23:22] zero
    logic [23:0] m_axis_tdata;
    // [0] bad_date
    logic        m_axis_tuser;

    date_diff_board board;
    int dates_sent    = 0;
    bit hold_active   = 1'b0;
    bit hold_done     = 1'b0;
    bit sender_steady = 1'b0;

    signed_date_difference_days_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic t_cal_date make_date(int y, int m, int d);
        t_cal_date dt;
        dt.year  = 12'(y);
        dt.month = 4'(m);
        dt.day   = 5'(d);
        return dt;
    endfunction

    // Favor the year extremes and the century leap rules a little.
    function automatic t_cal_date random_valid_date();
        int y;
        int m;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            y = 1;
        else if (r < 16)
            y = sdd_pkg::YEAR_MAX;
        else if (r < 26)
            y = 100 * $urandom_range(1, 29);
        else
            y = $urandom_range(1, sdd_pkg::YEAR_MAX);
        m = $urandom_range(1, sdd_pkg::MONTH_MAX);
        return make_date(y, m, $urandom_range(1, board.days_in_month(y, m)));
    endfunction

    // Offer one pair of dates, hold it until the transfer, then idle at random.
    task automatic send_dates(t_cal_date a, t_cal_date b, logic end_day);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, b.day, b.month, b.year, a.day, a.month, a.year};
        s_axis_tuser  <= end_day;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_dates(a, b, end_day);
        dates_sent++;
        // keep offering during the receiver hold-off so the block backs up
        gap = (sender_steady || hold_active) ? 0 : idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Compare every output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_difference($signed(m_axis_tdata[sdd_pkg::DIFF_W-1:0]), m_axis_tuser);
    end

    // Receiver: ready stretches of random length, random stalls, one long hold-off.
    initial begin
        int run;
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!hold_done && dates_sent >= HOLD_AFTER) begin
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
                repeat (run) @(posedge i_clk);
                gap = idle_cycles();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        t_cal_date a;
        t_cal_date b;
        int        kind;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Equal dates with and without the end day.
        send_dates(make_date(1, 1, 1), make_date(1, 1, 1), 1'b0);
        send_dates(make_date(1, 1, 1), make_date(1, 1, 1), 1'b1);
        // Widest spans in both directions.
        send_dates(make_date(1, 1, 1), make_date(2999, 12, 31), 1'b1);
        send_dates(make_date(2999, 12, 31), make_date(1, 1, 1), 1'b1);
        send_dates(make_date(2999, 12, 31), make_date(1, 1, 1), 1'b0);
        // Leap rules: every 400 years, not every 100, every 4.
        send_dates(make_date(2000, 2, 29), make_date(2000, 3, 1), 1'b0);
        send_dates(make_date(1900, 2, 29), make_date(1900, 3, 1), 1'b0);
        send_dates(make_date(2004, 2, 29), make_date(2003, 2, 28), 1'b1);
        send_dates(make_date(2003, 1, 1), make_date(2001, 2, 29), 1'b0);
        send_dates(make_date(1600, 2, 29), make_date(1700, 3, 1), 1'b1);
        send_dates(make_date(1999, 12, 31), make_date(2000, 1, 1), 1'b0);
        // Out-of-range years, months and days.
        send_dates(make_date(0, 6, 15), make_date(2000, 6, 15), 1'b0);
        send_dates(make_date(2000, 6, 15), make_date(3000, 6, 15), 1'b1);
        send_dates(make_date(4095, 15, 31), make_date(4095, 15, 31), 1'b1);
        send_dates(make_date(2000, 0, 10), make_date(2000, 1, 10), 1'b0);
        send_dates(make_date(2000, 13, 10), make_date(2000, 1, 10), 1'b0);
        send_dates(make_date(2000, 5, 0), make_date(2000, 5, 1), 1'b0);
        send_dates(make_date(2000, 5, 1), make_date(2000, 4, 31), 1'b1);
        send_dates(make_date(0, 0, 0), make_date(0, 0, 0), 1'b0);

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            // switch between idling and back-to-back phases
            if (i % 50 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            a = random_valid_date();
            b = random_valid_date();
            if (kind < 15) begin
                // same month, often the same date
                b = a;
                if ($urandom_range(0, 2) != 0)
                    b.day = 5'($urandom_range(1, board.days_in_month(a.year, a.month)));
            end else if (kind < 27) begin
                case ($urandom_range(0, 3))
                    0: a.day = '0;
                    1: b.month = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(13, 15))
                                                             : 4'd0;
                    2: b.year = 12'($urandom_range(sdd_pkg::YEAR_MAX + 1, 4095));
                    default: begin
                        b.month = sdd_pkg::MONTH_FEB;
                        b.day   = 5'($urandom_range(30, 31));
                    end
                endcase
            end else if (kind < 37) begin
                // raw bits in every field
                a = t_cal_date'(21'($urandom));
                b = t_cal_date'(21'($urandom));
            end
            send_dates(a, b, 1'($urandom_range(0, 1)));
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give the pipeline time to show any extra transfer.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("signed_date_difference_days_top verification clean");
        else
            $display("signed_date_difference_days_top verification failed");
        $finish;
    end

    initial begin
        #10000000;
        $display("signed_date_difference_days_top verification failed");
        $finish;
    end

endmodule
